FILE: hdl/ip_pair_session_table_assert.svh
// ----------------------------------------------------------------------------
// ip_pair_session_table assertion macros
// Shared concurrent assertion forms for the session table RTL.
// ----------------------------------------------------------------------------
`ifndef IP_PAIR_SESSION_TABLE_ASSERT_SVH
`define IP_PAIR_SESSION_TABLE_ASSERT_SVH

// condition holds at every edge out of reset
`define IPST_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define IPST_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define IPST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/ipst_pkg.sv
// ----------------------------------------------------------------------------
// ipst_pkg
// Types, codes and hash helpers shared by the session table modules.
// ----------------------------------------------------------------------------
package ipst_pkg;

    localparam int KEY_W = 32;

    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_FREE   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DUP       = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam int ROT_V4 = 4;
    localparam int ROT_V6 = 2;

    localparam logic [KEY_W-1:0] SEED_RST = 32'd1;
    localparam logic [KEY_W-1:0] SEED_MIN = 32'd1;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef struct packed {
        logic [1:0]       req_type;
        logic [5:0]       free_index;
        logic [KEY_W-1:0] key_add;
        logic [KEY_W-1:0] key_xor;
    } cmd_t;

    function automatic logic [KEY_W-1:0] fold(
        input logic [KEY_W-1:0] a,
        input logic             is_v6,
        input logic [KEY_W-1:0] w
    );
        logic [KEY_W-1:0] rot;
        if (is_v6) begin
            rot = (a << ROT_V6) | (a >> (KEY_W - ROT_V6));
        end else begin
            rot = (a << ROT_V4) | (a >> (KEY_W - ROT_V4));
        end
        return rot + w;
    endfunction

endpackage

FILE: hdl/ipst_front.sv
// ----------------------------------------------------------------------------
// ipst_front
// Accepts requests and folds the address pair into the two keys, one word
// per cycle, then hands the command to the queue.
// ----------------------------------------------------------------------------
module ipst_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [ipst_pkg::KEY_W-1:0] hash_seed,
    input  logic                       hold_off,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_req_type,
    input  logic                       s_local_is_v6,
    input  logic [31:0]                s_local_word0,
    input  logic [31:0]                s_local_word1,
    input  logic [31:0]                s_local_word2,
    input  logic [31:0]                s_local_word3,
    input  logic                       s_remote_is_v6,
    input  logic [31:0]                s_remote_word0,
    input  logic [31:0]                s_remote_word1,
    input  logic [31:0]                s_remote_word2,
    input  logic [31:0]                s_remote_word3,
    input  logic [5:0]                 s_free_index,
    output logic                       q_valid,
    output ipst_pkg::cmd_t             q_data,
    input  logic                       q_ready
);
    import ipst_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_HASH = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [2:0]       step_reg, step_next;
    logic [KEY_W-1:0] a_reg, a_next;
    logic [KEY_W-1:0] x_reg, x_next;
    logic [1:0]       req_reg;
    logic             lv6_reg;
    logic             rv6_reg;
    logic [31:0]      lw_reg [4];
    logic [31:0]      rw_reg [4];
    logic [5:0]       fidx_reg;

    logic             load;
    logic [KEY_W-1:0] seed_eff;
    logic [KEY_W-1:0] first_add;
    logic [2:0]       lcnt;
    logic [2:0]       last_step;
    logic [2:0]       rstep;
    logic [31:0]      word;
    logic             rot_v6;

    assign seed_eff  = (hash_seed == '0) ? SEED_MIN : hash_seed;
    assign first_add = seed_eff + s_local_word0;
    assign lcnt      = lv6_reg ? 3'd3 : 3'd1;
    assign last_step = lcnt + (rv6_reg ? 3'd4 : 3'd2) - 3'd1;
    assign rstep     = step_reg - lcnt;

    always_comb begin
        if (step_reg < lcnt) begin
            word   = lv6_reg ? lw_reg[2'(step_reg + 3'd1)] : lw_reg[0];
            rot_v6 = lv6_reg;
        end else begin
            word   = rv6_reg ? rw_reg[rstep[1:0]] : rw_reg[0];
            rot_v6 = rv6_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        a_next     = a_reg;
        x_next     = x_reg;
        load       = 1'b0;
        case (state_reg)
            F_IDLE: begin
                if (s_valid && s_ready) begin
                    load       = 1'b1;
                    a_next     = first_add;
                    x_next     = first_add;
                    step_next  = '0;
                    state_next = F_HASH;
                end
            end
            F_HASH: begin
                a_next    = fold(a_reg, rot_v6, word);
                x_next    = x_reg ^ a_next;
                step_next = step_reg + 3'd1;
                if (step_reg == last_step) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (q_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        x_reg <= x_next;
        if (load) begin
            req_reg   <= s_req_type;
            lv6_reg   <= s_local_is_v6;
            rv6_reg   <= s_remote_is_v6;
            lw_reg[0] <= s_local_word0;
            lw_reg[1] <= s_local_word1;
            lw_reg[2] <= s_local_word2;
            lw_reg[3] <= s_local_word3;
            rw_reg[0] <= s_remote_word0;
            rw_reg[1] <= s_remote_word1;
            rw_reg[2] <= s_remote_word2;
            rw_reg[3] <= s_remote_word3;
            fidx_reg  <= s_free_index;
        end
    end

    assign s_ready = (state_reg == F_IDLE) && !hold_off;
    assign q_valid = (state_reg == F_PUSH);

    always_comb begin
        q_data.req_type   = req_reg;
        q_data.free_index = fidx_reg;
        q_data.key_add    = (a_reg == '0) ? seed_eff : a_reg;
        q_data.key_xor    = x_reg;
    end

endmodule

FILE: hdl/ipst_fifo.sv
// ----------------------------------------------------------------------------
// ipst_fifo
// Short command queue between the hashing front and the table engine.
// ----------------------------------------------------------------------------
module ipst_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  ipst_pkg::cmd_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ipst_pkg::cmd_t out_data
);
    import ipst_pkg::*;

    cmd_t            entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg, count_next;
    logic            push;
    logic            pop;

    assign in_ready  = (count_reg != (Q_AW+1)'(Q_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

FILE: hdl/ipst_engine.sv
// ----------------------------------------------------------------------------
// ipst_engine
// Key store, high-water mark and the scan sequencer that carries out
// allocate, lookup and free commands. Clears the key store after reset.
// ----------------------------------------------------------------------------
`include "ip_pair_session_table_assert.svh"

module ipst_engine #(
    parameter int SESSIONS = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  ipst_pkg::cmd_t             cmd_in,
    output logic                       clearing,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [5:0]                 m_slot_index,
    output logic [ipst_pkg::KEY_W-1:0] m_key_add_out,
    output logic [ipst_pkg::KEY_W-1:0] m_key_xor_out
);
    import ipst_pkg::*;

    localparam int IW = $clog2(SESSIONS);
    localparam int CW = $clog2(SESSIONS + 1);
    localparam int DW = 2 * KEY_W;

    localparam logic [2:0] E_CLEAR  = 3'd0;
    localparam logic [2:0] E_IDLE   = 3'd1;
    localparam logic [2:0] E_SCAN   = 3'd2;
    localparam logic [2:0] E_ALLOC  = 3'd3;
    localparam logic [2:0] E_FREE   = 3'd4;
    localparam logic [2:0] E_SHRINK = 3'd5;
    localparam logic [2:0] E_DONE   = 3'd6;

    logic [DW-1:0]  mem [SESSIONS];

    logic [2:0]     state_reg, state_next;
    logic [CW-1:0]  hw_reg, hw_next;
    logic [CW-1:0]  iss_reg, iss_next;
    logic [IW-1:0]  clr_reg, clr_next;
    logic           free_found_reg, free_found_next;
    logic [IW-1:0]  free_slot_reg, free_slot_next;
    logic [IW-1:0]  alloc_slot_reg, alloc_slot_next;
    logic [1:0]     res_status_reg, res_status_next;
    logic [5:0]     res_slot_reg, res_slot_next;
    logic           rd_valid_reg;
    logic [IW-1:0]  rd_idx_reg;
    logic [DW-1:0]  rd_data_reg;
    cmd_t           cmd_reg;
    logic           out_valid_reg, out_valid_next;
    logic [1:0]     out_status_reg;
    logic [5:0]     out_slot_reg;
    logic [KEY_W-1:0] out_add_reg;
    logic [KEY_W-1:0] out_xor_reg;

    logic           cmd_load;
    logic           out_load;
    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    logic [DW-1:0]  mem_wdata;
    logic           mem_re;
    logic [IW-1:0]  mem_raddr;

    logic [KEY_W-1:0] d_add;
    logic [KEY_W-1:0] d_xor;
    logic           hit;
    logic           rd_last;
    logic [CW-1:0]  alloc_top;
    logic [IW-1:0]  fidx;
    logic [CW-1:0]  fidx_top;
    logic           idx_ok;
    logic [CW-1:0]  shr_addr;

    assign d_add     = rd_data_reg[DW-1:KEY_W];
    assign d_xor     = rd_data_reg[KEY_W-1:0];
    assign hit       = rd_valid_reg && (d_add != '0) && (d_add == cmd_reg.key_add)
                       && (d_xor == cmd_reg.key_xor);
    assign rd_last   = rd_valid_reg && (CW'(rd_idx_reg) == hw_reg - 1'b1);
    assign alloc_top = CW'(alloc_slot_reg) + 1'b1;
    assign fidx      = IW'(cmd_reg.free_index);
    assign fidx_top  = CW'(fidx) + 1'b1;
    assign idx_ok    = 32'(cmd_reg.free_index) < 32'(SESSIONS);
    assign shr_addr  = iss_reg - 1'b1;

    always_comb begin
        state_next      = state_reg;
        hw_next         = hw_reg;
        iss_next        = iss_reg;
        clr_next        = clr_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        alloc_slot_next = alloc_slot_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        cmd_load        = 1'b0;
        out_load        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        case (state_reg)
            E_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IW'(SESSIONS - 1)) begin
                    state_next = E_IDLE;
                end
            end
            E_IDLE: begin
                if (cmd_valid) begin
                    cmd_load        = 1'b1;
                    iss_next        = '0;
                    free_found_next = 1'b0;
                    case (cmd_in.req_type)
                        REQ_ALLOC: begin
                            if (hw_reg == '0) begin
                                alloc_slot_next = '0;
                                state_next      = E_ALLOC;
                            end else begin
                                state_next = E_SCAN;
                            end
                        end
                        REQ_LOOKUP: begin
                            if (hw_reg == '0) begin
                                res_status_next = ST_NOT_FOUND;
                                res_slot_next   = '0;
                                state_next      = E_DONE;
                            end else begin
                                state_next = E_SCAN;
                            end
                        end
                        REQ_FREE: begin
                            state_next = E_FREE;
                        end
                        default: begin
                            res_status_next = ST_NOT_FOUND;
                            res_slot_next   = '0;
                            state_next      = E_DONE;
                        end
                    endcase
                end
            end
            E_SCAN: begin
                if (iss_reg < hw_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = iss_reg[IW-1:0];
                    iss_next  = iss_reg + 1'b1;
                end
                if (rd_valid_reg && (d_add == '0) && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_slot_next  = rd_idx_reg;
                end
                if (hit) begin
                    res_status_next = (cmd_reg.req_type == REQ_LOOKUP) ? ST_OK : ST_DUP;
                    res_slot_next   = 6'(rd_idx_reg);
                    state_next      = E_DONE;
                end else if (rd_last) begin
                    if (cmd_reg.req_type == REQ_LOOKUP) begin
                        res_status_next = ST_NOT_FOUND;
                        res_slot_next   = '0;
                        state_next      = E_DONE;
                    end else if (free_found_reg) begin
                        alloc_slot_next = free_slot_reg;
                        state_next      = E_ALLOC;
                    end else if (d_add == '0) begin
                        alloc_slot_next = rd_idx_reg;
                        state_next      = E_ALLOC;
                    end else if (hw_reg < CW'(SESSIONS)) begin
                        alloc_slot_next = hw_reg[IW-1:0];
                        state_next      = E_ALLOC;
                    end else begin
                        res_status_next = ST_FULL;
                        res_slot_next   = '0;
                        state_next      = E_DONE;
                    end
                end
            end
            E_ALLOC: begin
                mem_we    = 1'b1;
                mem_waddr = alloc_slot_reg;
                mem_wdata = {cmd_reg.key_add, cmd_reg.key_xor};
                if (alloc_top > hw_reg) begin
                    hw_next = alloc_top;
                end
                res_status_next = ST_OK;
                res_slot_next   = 6'(alloc_slot_reg);
                state_next      = E_DONE;
            end
            E_FREE: begin
                res_slot_next = cmd_reg.free_index;
                state_next    = E_DONE;
                if (!idx_ok) begin
                    res_status_next = ST_NOT_FOUND;
                end else begin
                    mem_we          = 1'b1;
                    mem_waddr       = fidx;
                    res_status_next = ST_OK;
                    if (fidx_top == hw_reg) begin
                        if (fidx == '0) begin
                            hw_next = '0;
                        end else begin
                            iss_next   = CW'(fidx);
                            state_next = E_SHRINK;
                        end
                    end
                end
            end
            E_SHRINK: begin
                if (iss_reg != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = shr_addr[IW-1:0];
                    iss_next  = shr_addr;
                end
                if (rd_valid_reg) begin
                    if (d_add != '0) begin
                        hw_next    = CW'(rd_idx_reg) + 1'b1;
                        state_next = E_DONE;
                    end else if (rd_idx_reg == '0) begin
                        hw_next    = '0;
                        state_next = E_DONE;
                    end
                end
            end
            E_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = E_IDLE;
                end
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= E_CLEAR;
            hw_reg         <= '0;
            clr_reg        <= '0;
            free_found_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            hw_reg         <= hw_next;
            clr_reg        <= clr_next;
            free_found_reg <= free_found_next;
            rd_valid_reg   <= mem_re;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        iss_reg        <= iss_next;
        free_slot_reg  <= free_slot_next;
        alloc_slot_reg <= alloc_slot_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        rd_idx_reg     <= mem_raddr;
        if (cmd_load) begin
            cmd_reg <= cmd_in;
        end
        if (out_load) begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_add_reg    <= cmd_reg.key_add;
            out_xor_reg    <= cmd_reg.key_xor;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign cmd_ready     = (state_reg == E_IDLE);
    assign clearing      = (state_reg == E_CLEAR);
    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_slot_index  = out_slot_reg;
    assign m_key_add_out = out_add_reg;
    assign m_key_xor_out = out_xor_reg;

    `IPST_ASSERT_ALWAYS(a_hw_range, aclk, aresetn, hw_reg <= CW'(SESSIONS), "high-water mark beyond table")
    `IPST_ASSERT_NEXT(a_alloc_hw, aclk, aresetn, state_reg == E_ALLOC, hw_reg > CW'(alloc_slot_reg), "allocated slot above high-water mark")
    `IPST_ASSERT_NEXT(a_pop_busy, aclk, aresetn, cmd_valid && cmd_ready, state_reg != E_IDLE, "command taken but engine stayed idle")
    `IPST_ASSERT_NEXT(a_done_out, aclk, aresetn, (state_reg == E_DONE) && (!out_valid_reg || m_ready), out_valid_reg, "finished request not presented")

endmodule

FILE: hdl/ip_pair_session_table.sv
// Hashing folds one address word per cycle; the engine then scans the key store up to
// the high-water mark for allocate or lookup, clears one entry for free, and scans
// down again when a free shrinks the high-water mark.
// Throughput is bounded by the engine's one-entry-per-cycle scan of the key store.
// Reset (aresetn low, synchronous) starts a clearing pass over the whole key
// store; no request is accepted until it ends.
// ----------------------------------------------------------------------------
// ip_pair_session_table
// Session table keyed by a hashed local/remote IPv4 or IPv6 address pair.
// ----------------------------------------------------------------------------
module ip_pair_session_table #(
    parameter int SESSIONS = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [ipst_pkg::KEY_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_req_type,
    input  logic                       s_local_is_v6,
    input  logic [31:0]                s_local_word0,
    input  logic [31:0]                s_local_word1,
    input  logic [31:0]                s_local_word2,
    input  logic [31:0]                s_local_word3,
    input  logic                       s_remote_is_v6,
    input  logic [31:0]                s_remote_word0,
    input  logic [31:0]                s_remote_word1,
    input  logic [31:0]                s_remote_word2,
    input  logic [31:0]                s_remote_word3,
    input  logic [5:0]                 s_free_index,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [5:0]                 m_slot_index,
    output logic [31:0]                m_key_add_out,
    output logic [31:0]                m_key_xor_out
);
    import ipst_pkg::*;

    logic [KEY_W-1:0] hash_seed_reg;
    logic             clearing;
    logic             fq_valid;
    logic             fq_ready;
    cmd_t             fq_data;
    logic             qe_valid;
    logic             qe_ready;
    cmd_t             qe_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_seed_reg <= SEED_RST;
        end else if (cfg_wr_en) begin
            hash_seed_reg <= cfg_wr_data;
        end
    end

    ipst_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .hash_seed      (hash_seed_reg),
        .hold_off       (clearing),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_local_is_v6  (s_local_is_v6),
        .s_local_word0  (s_local_word0),
        .s_local_word1  (s_local_word1),
        .s_local_word2  (s_local_word2),
        .s_local_word3  (s_local_word3),
        .s_remote_is_v6 (s_remote_is_v6),
        .s_remote_word0 (s_remote_word0),
        .s_remote_word1 (s_remote_word1),
        .s_remote_word2 (s_remote_word2),
        .s_remote_word3 (s_remote_word3),
        .s_free_index   (s_free_index),
        .q_valid        (fq_valid),
        .q_data         (fq_data),
        .q_ready        (fq_ready)
    );

    ipst_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qe_valid),
        .out_ready (qe_ready),
        .out_data  (qe_data)
    );

    ipst_engine #(
        .SESSIONS (SESSIONS)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (qe_valid),
        .cmd_ready     (qe_ready),
        .cmd_in        (qe_data),
        .clearing      (clearing),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_slot_index  (m_slot_index),
        .m_key_add_out (m_key_add_out),
        .m_key_xor_out (m_key_xor_out)
    );

endmodule
